/* sv/bone_vertex_skinning_transform_top_assert.svh */
`ifndef BONE_VERTEX_SKINNING_TRANSFORM_TOP_ASSERT_SVH
`define BONE_VERTEX_SKINNING_TRANSFORM_TOP_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define BVS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bvs assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define BVS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bvs assertion failed");
`endif

/* sv/bvs_pkg.sv */
`timescale 1ns / 1ps
package bvs_pkg;
    localparam int WORDS_PER_BONE = 12;
    localparam int WORD_W = 32;
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_VERTEX = 1'b1;

    typedef struct packed {
        logic                     last;
        logic                     zero;
        logic signed [WORD_W-1:0] px;
        logic signed [WORD_W-1:0] py;
        logic signed [WORD_W-1:0] pz;
        logic signed [WORD_W-1:0] nx;
        logic signed [WORD_W-1:0] ny;
        logic signed [WORD_W-1:0] nz;
    } vtx_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] x;
        logic signed [WORD_W-1:0] y;
        logic signed [WORD_W-1:0] z;
        logic signed [WORD_W-1:0] nx;
        logic signed [WORD_W-1:0] ny;
        logic signed [WORD_W-1:0] nz;
        logic                     last;
    } res_t;
endpackage

/* sv/bvs_ram.sv */
`timescale 1ns / 1ps
module bvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* sv/bvs_front.sv */
`timescale 1ns / 1ps
module bvs_front #(
    parameter int BONE_COUNT = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid,
    output logic                          stall,
    input  logic                          mode,
    input  logic [5:0]                    bone_index,
    input  logic [3:0]                    word_index,
    input  logic signed [31:0]            word_value,
    input  logic signed [31:0]            pos_x,
    input  logic signed [31:0]            pos_y,
    input  logic signed [31:0]            pos_z,
    input  logic signed [31:0]            nrm_x,
    input  logic signed [31:0]            nrm_y,
    input  logic signed [31:0]            nrm_z,
    input  logic                          last_vertex,
    input  logic                          q_full,
    output logic                          q_push,
    output bvs_pkg::vtx_t                 q_data,
    output logic [bvs_pkg::WORD_W*12-1:0] mat_rdata
);
    import bvs_pkg::*;
    localparam int BW = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;

    logic        acc;
    logic        in_range;
    logic [11:0] wsel;
    logic        vld_reg;
    vtx_t        vtx_reg;

    assign stall = q_full;
    assign acc = valid && !stall;
    assign in_range = ({26'd0, bone_index} < 32'(BONE_COUNT));

    always_comb
    begin
        wsel = '0;
        if (acc && mode == MODE_WRITE && in_range && word_index < 4'(WORDS_PER_BONE))
        begin
            wsel[word_index] = 1'b1;
        end
    end

    genvar g;
    generate
        for (g = 0; g < WORDS_PER_BONE; g++)
        begin : g_col
            bvs_ram #(.WIDTH(WORD_W), .DEPTH(BONE_COUNT)) u_ram (
                .clk   (clk),
                .we    (wsel[g]),
                .waddr (BW'(bone_index)),
                .wdata (word_value),
                .re    (acc && mode == MODE_VERTEX),
                .raddr (BW'(bone_index)),
                .rdata (mat_rdata[g*WORD_W +: WORD_W])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= acc && mode == MODE_VERTEX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && mode == MODE_VERTEX)
        begin
            vtx_reg <= '{last_vertex, !in_range, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z};
        end
    end

    assign q_push = vld_reg;
    assign q_data = vtx_reg;
endmodule

/* sv/bvs_back.sv */
`timescale 1ns / 1ps
module bvs_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_push,
    input  bvs_pkg::vtx_t                 q_data,
    input  logic [bvs_pkg::WORD_W*12-1:0] mat_rdata,
    output logic                          q_full,
    output logic                          valid,
    input  logic                          stall,
    output bvs_pkg::res_t                 res
);
    import bvs_pkg::*;
    `include "bone_vertex_skinning_transform_top_assert.svh"

    localparam int QD = 4;
    localparam int QW = 2;
    localparam int SHW = 64 - FRAC_BITS;
    localparam int SUMW = SHW + 2;

    // queue holds vertex and its matrix; entries sized for front latency
    vtx_t              qv_reg [QD];
    logic [WORD_W*12-1:0] qm_reg [QD];
    logic [QW-1:0]     wp_reg, rp_reg;
    logic [QW:0]       cnt_reg;
    logic              pop;
    logic              s1_vld_reg, s2_vld_reg, o_vld_reg;
    logic              adv1, adv2, advo;
    logic signed [WORD_W-1:0] m [12];
    logic signed [WORD_W-1:0] mm_reg [12];
    vtx_t              v1_reg, v2_reg;
    logic signed [63:0] p_reg [18];
    logic signed [63:0] pn [18];
    logic signed [SHW-1:0] sh [18];
    logic signed [SUMW-1:0] sum [6];
    logic signed [WORD_W-1:0] sat [6];
    res_t              o_reg;
    logic [3:0]        inflight;

    // stall front while queue plus in-flight front stage might overflow
    assign inflight = 4'(cnt_reg) + 4'(q_push);
    assign q_full = (inflight >= 4'(QD - 1));

    assign advo = !o_vld_reg || !stall;
    assign adv2 = !s2_vld_reg || advo;
    assign adv1 = !s1_vld_reg || adv2;
    assign pop = (cnt_reg != '0) && adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else
        begin
            if (q_push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QW+1)'(q_push) - (QW+1)'(pop);
            if (adv1)
            begin
                s1_vld_reg <= pop;
            end
            if (adv2)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (advo)
            begin
                o_vld_reg <= s2_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            qv_reg[wp_reg] <= q_data;
            qm_reg[wp_reg] <= mat_rdata;
        end
        if (adv1 && pop)
        begin
            v1_reg <= qv_reg[rp_reg];
            for (int k = 0; k < 12; k++)
            begin
                mm_reg[k] <= qm_reg[rp_reg][k*WORD_W +: WORD_W];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 12; k++)
        begin
            m[k] = v1_reg.zero ? '0 : mm_reg[k];
        end
        for (int j = 0; j < 3; j++)
        begin
            pn[j*6+0] = 64'(v1_reg.px) * 64'(m[j]);
            pn[j*6+1] = 64'(v1_reg.py) * 64'(m[3+j]);
            pn[j*6+2] = 64'(v1_reg.pz) * 64'(m[6+j]);
            pn[j*6+3] = 64'(v1_reg.nx) * 64'(m[j]);
            pn[j*6+4] = 64'(v1_reg.ny) * 64'(m[3+j]);
            pn[j*6+5] = 64'(v1_reg.nz) * 64'(m[6+j]);
        end
    end

    logic signed [WORD_W-1:0] tr_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_vld_reg)
        begin
            for (int k = 0; k < 18; k++)
            begin
                p_reg[k] <= pn[k];
            end
            for (int j = 0; j < 3; j++)
            begin
                tr_reg[j] <= m[9+j];
            end
            v2_reg <= v1_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 18; k++)
        begin
            sh[k] = SHW'(p_reg[k] >>> FRAC_BITS);
        end
        for (int j = 0; j < 3; j++)
        begin
            sum[j] = SUMW'(sh[j*6+0]) + SUMW'(sh[j*6+1])
                + SUMW'(sh[j*6+2]) + SUMW'(tr_reg[j]);
            sum[3+j] = SUMW'(sh[j*6+3]) + SUMW'(sh[j*6+4])
                + SUMW'(sh[j*6+5]);
        end
        for (int k = 0; k < 6; k++)
        begin
            if (sum[k] > SUMW'(32'sh7fffffff))
            begin
                sat[k] = 32'sh7fffffff;
            end
            else if (sum[k] < SUMW'(32'sh80000000))
            begin
                sat[k] = 32'sh80000000;
            end
            else
            begin
                sat[k] = sum[k][WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advo && s2_vld_reg)
        begin
            o_reg <= '{sat[0], sat[1], sat[2], sat[3], sat[4], sat[5], v2_reg.last};
        end
    end

    assign valid = o_vld_reg;
    assign res = o_reg;

    `BVS_ASSERT_IMP(a_no_overflow, q_push, cnt_reg < (QW+1)'(QD))
    `BVS_ASSERT_IMP(a_no_underflow, pop, cnt_reg != '0)
    `BVS_ASSERT_NEXT(a_out_hold, valid && stall, valid && $stable(res))
endmodule

/* sv/bone_vertex_skinning_transform_top.sv */
`timescale 1ns / 1ps
// Single-bone vertex skinning in signed Q16.16. Write items (mode 0) load one
// matrix word of a bone; vertex items (mode 1) return the position transformed
// with translation and the normal without it, saturated to 32 bits. One item is
// taken per cycle while in_stall is low. The matrix table is twelve column RAMs
// read in parallel, and a four-entry queue between the table read and the
// three-stage multiply/sum pipeline absorbs output stalls. Reading a matrix
// word never written gives an undefined result.
module bone_vertex_skinning_transform_top #(
    parameter int BONE_COUNT = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [5:0]         bone_index,
    input  logic [3:0]         word_index,
    input  logic signed [31:0] word_value,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] nrm_x,
    input  logic signed [31:0] nrm_y,
    input  logic signed [31:0] nrm_z,
    input  logic               last_vertex,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_pos_x,
    output logic signed [31:0] out_pos_y,
    output logic signed [31:0] out_pos_z,
    output logic signed [31:0] out_nrm_x,
    output logic signed [31:0] out_nrm_y,
    output logic signed [31:0] out_nrm_z,
    output logic               out_last
);
    import bvs_pkg::*;

    logic                 q_full;
    logic                 q_push;
    vtx_t                 q_data;
    logic [WORD_W*12-1:0] mat_rdata;
    res_t                 res;

    bvs_front #(.BONE_COUNT(BONE_COUNT)) u_front (
        .clk, .rst_n, .valid(in_valid), .stall(in_stall), .mode, .bone_index,
        .word_index, .word_value, .pos_x, .pos_y, .pos_z, .nrm_x, .nrm_y, .nrm_z,
        .last_vertex, .q_full, .q_push, .q_data, .mat_rdata
    );

    bvs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk, .rst_n, .q_push, .q_data, .mat_rdata, .q_full,
        .valid(out_valid), .stall(out_stall), .res
    );

    assign out_pos_x = res.x;
    assign out_pos_y = res.y;
    assign out_pos_z = res.z;
    assign out_nrm_x = res.nx;
    assign out_nrm_y = res.ny;
    assign out_nrm_z = res.nz;
    assign out_last = res.last;
endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
module tb;
    import bvs_pkg::*;

    typedef struct {
        logic              mode;
        logic [5:0]        bone;
        logic [3:0]        word;
        logic signed [31:0] wval;
        logic signed [31:0] p [3];
        logic signed [31:0] n [3];
        logic              last;
    } skin_item_t;

    typedef struct {
        logic signed [31:0] p [3];
        logic signed [31:0] n [3];
        logic              last;
    } skin_out_t;

    localparam int MAX_CYCLES = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic mode = 1'b0;
    logic [5:0] bone_index = '0;
    logic [3:0] word_index = '0;
    logic signed [31:0] word_value = '0;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [31:0] nrm_x = '0, nrm_y = '0, nrm_z = '0;
    logic last_vertex = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
    logic signed [31:0] out_nrm_x, out_nrm_y, out_nrm_z;
    logic out_last;

    bone_vertex_skinning_transform_top u_dut (.*);

    always #5 clk = ~clk;

    skin_item_t pending_items[$];
    skin_out_t  expected_vertices[$];
    logic signed [31:0] bone_table [64][12];
    bit written [64][12];
    int errors = 0;
    int cycles = 0;
    bit hold_sender = 1'b0;
    int in_gap = 0;
    int out_gap = 0;

    function automatic logic signed [63:0] scaled_product(logic signed [31:0] a,
                                                          logic signed [31:0] b);
        logic signed [63:0] prod;
        prod = 64'(a) * 64'(b);
        return prod >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic void skin_predict(skin_item_t it);
        skin_out_t r;
        logic signed [31:0] m [12];
        logic signed [63:0] acc;
        if (it.mode == MODE_WRITE)
        begin
            if (it.word < WORDS_PER_BONE)
            begin
                bone_table[it.bone][it.word] = it.wval;
                written[it.bone][it.word] = 1'b1;
            end
            return;
        end
        for (int k = 0; k < 12; k++)
            m[k] = bone_table[it.bone][k];
        for (int j = 0; j < 3; j++)
        begin
            acc = scaled_product(it.p[0], m[j]) + scaled_product(it.p[1], m[3 + j])
                + scaled_product(it.p[2], m[6 + j]) + 64'(m[9 + j]);
            r.p[j] = clamp32(acc);
            acc = scaled_product(it.n[0], m[j]) + scaled_product(it.n[1], m[3 + j])
                + scaled_product(it.n[2], m[6 + j]);
            r.n[j] = clamp32(acc);
        end
        r.last = it.last;
        expected_vertices.push_back(r);
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'(int'($urandom_range(0, 262144)) - 131072);
            3: return 32'(int'($urandom_range(0, 16777216)) - 8388608);
            default: return $urandom;
        endcase
    endfunction

    function automatic skin_item_t make_write(int b, int w, logic signed [31:0] v);
        skin_item_t it;
        it.mode = MODE_WRITE;
        it.bone = 6'(b);
        it.word = 4'(w);
        it.wval = v;
        for (int k = 0; k < 3; k++)
        begin
            it.p[k] = $urandom;
            it.n[k] = $urandom;
        end
        it.last = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic skin_item_t make_vertex(int b, logic signed [31:0] v);
        skin_item_t it;
        it.mode = MODE_VERTEX;
        it.bone = 6'(b);
        it.word = 4'($urandom_range(0, 15));
        it.wval = $urandom;
        for (int k = 0; k < 3; k++)
        begin
            it.p[k] = v;
            it.n[k] = v;
        end
        it.last = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic void load_bone(int b, bit unit);
        for (int w = 0; w < 12; w++)
            pending_items.push_back(make_write(b, w,
                unit ? ((w % 4 == 0 && w < 9) ? 32'sh10000 : 32'sh0) : rand_word()));
    endfunction

    function automatic bit bone_ready(int b);
        for (int w = 0; w < 12; w++)
            if (!written[b][w])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic skin_item_t random_vertex();
        skin_item_t it;
        it = make_vertex(0, 0);
        it.bone = 6'($urandom_range(0, 7));
        for (int k = 0; k < 3; k++)
        begin
            it.p[k] = rand_word();
            it.n[k] = rand_word();
        end
        return it;
    endfunction

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        load_bone(0, 1'b1);
        pending_items.push_back(make_vertex(0, 32'sh7fffffff));
        pending_items.push_back(make_vertex(0, 32'sh80000000));
        load_bone(63, 1'b0);
        pending_items.push_back(make_write(63, 0, 32'sh7fffffff));
        pending_items.push_back(make_write(63, 3, 32'sh7fffffff));
        pending_items.push_back(make_write(63, 12, 32'sh12345));
        pending_items.push_back(make_write(63, 15, 32'sh80000000));
        pending_items.push_back(make_vertex(63, 32'sh7fffffff));
        pending_items.push_back(make_vertex(63, 32'sh80000000));
        for (int b = 1; b < 8; b++)
            load_bone(b, 1'b0);
        wait (pending_items.size() == 0 && expected_vertices.size() == 0);
        hold_sender = 1'b1;
        repeat (8) @(posedge clk);
        hold_sender = 1'b0;
        for (int i = 0; i < 330; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                pending_items.push_back(make_write($urandom_range(0, 63),
                    $urandom_range(0, 15), rand_word()));
            else
                pending_items.push_back(random_vertex());
        end
        wait (pending_items.size() == 0 && expected_vertices.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        skin_item_t it;
        if (in_valid && !in_stall)
        begin
            in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            if ($urandom_range(0, 3) == 0)
                in_gap = 0;
        end
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (in_gap > 0 || hold_sender || pending_items.size() == 0)
            begin
                if (in_gap > 0)
                    in_gap--;
                in_valid <= 1'b0;
            end
            else
            begin
                it = pending_items.pop_front();
                if (it.mode == MODE_VERTEX && !bone_ready(it.bone))
                    it.bone = '0;
                skin_predict(it);
                in_valid <= 1'b1;
                mode <= it.mode;
                bone_index <= it.bone;
                word_index <= it.word;
                word_value <= it.wval;
                pos_x <= it.p[0];
                pos_y <= it.p[1];
                pos_z <= it.p[2];
                nrm_x <= it.n[0];
                nrm_y <= it.n[1];
                nrm_z <= it.n[2];
                last_vertex <= it.last;
            end
        end
    end

    task automatic compare_field(string name, logic signed [31:0] exp_v,
                                 logic signed [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s expected %0d actual %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        skin_out_t r;
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_vertices.size() == 0)
            begin
                $error("unexpected vertex result");
                errors++;
            end
            else
            begin
                r = expected_vertices.pop_front();
                compare_field("out_pos_x", r.p[0], out_pos_x);
                compare_field("out_pos_y", r.p[1], out_pos_y);
                compare_field("out_pos_z", r.p[2], out_pos_z);
                compare_field("out_nrm_x", r.n[0], out_nrm_x);
                compare_field("out_nrm_y", r.n[1], out_nrm_y);
                compare_field("out_nrm_z", r.n[2], out_nrm_z);
                compare_field("out_last", 32'(r.last), 32'(out_last));
            end
            out_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
        end
        if (out_gap > 0)
        begin
            out_gap--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end
endmodule

/* files.f */
+incdir+sv
sv/bvs_pkg.sv
sv/bvs_ram.sv
sv/bvs_front.sv
sv/bvs_back.sv
sv/bone_vertex_skinning_transform_top.sv
dv/tb.sv
